>>> hdl/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// Plain text macros, no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset
`define LCWS_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication under asynchronous active-low reset
`define LCWS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> hdl/lcws_pkg.sv
// Package for the LED color-wipe sequencer: sizes, constants, divider ops
// and the command/status structs between controller and datapath. No dependencies.
package lcws_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned POS_W   = 8;

  // Strip geometry and brightness range
  localparam int unsigned LED_COUNT = 16;
  localparam int unsigned LEVEL_MAX = 255;

  // Timing constants
  localparam int unsigned SYNC_SPAN = 60000;
  localparam int unsigned SWEEP_DIV = 2000;
  localparam int unsigned TICK_MS   = 10;

  // Derived sizes
  localparam int unsigned TICK_MAX = (SYNC_SPAN - 1) / TICK_MS;
  localparam int unsigned TICK_W   = $clog2(TICK_MAX + 1);
  localparam int unsigned SWEEP_K  = LED_COUNT * LEVEL_MAX;
  localparam int unsigned K_W      = $clog2(SWEEP_K + 1);
  localparam int unsigned PROD_W   = $clog2(SWEEP_K * TICK_MAX + 1);
  localparam int unsigned DIV_W    = (PROD_W > TIME_W) ? PROD_W : TIME_W;
  localparam int unsigned DVS_W    = $clog2(SWEEP_DIV + 1);

  // Reciprocal divides: q = (x * RECIP) >> SH is exact for every x below 2**N
  // when SH = N + clog2(divisor) and RECIP = ceil(2**SH / divisor)
  localparam int unsigned TICK_SH  = TIME_W + $clog2(TICK_MS);
  localparam int unsigned SWEEP_SH = PROD_W + $clog2(SWEEP_DIV);
  localparam int unsigned LEVEL_SH = TIME_W + $clog2(LEVEL_MAX);
  localparam longint unsigned TICK_RECIP  = ((64'd1 << TICK_SH) + TICK_MS - 1) / TICK_MS;
  localparam longint unsigned SWEEP_RECIP = ((64'd1 << SWEEP_SH) + SWEEP_DIV - 1) / SWEEP_DIV;
  localparam longint unsigned LEVEL_RECIP = ((64'd1 << LEVEL_SH) + LEVEL_MAX - 1) / LEVEL_MAX;
  localparam int unsigned REC_W    = DIV_W + 1;
  localparam int unsigned SH_W     = $clog2(DIV_W + DVS_W + 1);

  // Operations of the shared divider
  typedef enum logic [1:0] {
    DIV_OP_TICK,
    DIV_OP_SWEEP,
    DIV_OP_LEVEL
  } div_op_e;

  // Controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    adjust;
    logic    div_start;
    div_op_e div_op;
    logic    tick_take;
    logic    plan;
    logic    emit_all;
    logic    emit_fill;
    logic    emit_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic tick_repeat;
    logic need_all;
    logic fill_more;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/lcws_in_if.sv
// Input channel of the sequencer: valid/ready and the millisecond time.
// Depends on lcws_pkg.
interface lcws_in_if;
  logic                         valid;
  logic                         ready;
  logic [lcws_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

>>> hdl/lcws_out_if.sv
// Output channel of the sequencer: valid/ready and one LED write command.
// Depends on lcws_pkg.
interface lcws_out_if;
  logic                          valid;
  logic                          ready;
  logic                          write_all;
  logic [lcws_pkg::IDX_W-1:0]    led_index;
  logic [lcws_pkg::LEVEL_W-1:0]  red_level;
  logic [lcws_pkg::LEVEL_W-1:0]  green_level;
  logic [lcws_pkg::LEVEL_W-1:0]  blue_level;
  logic                          last_write;

  modport source (output valid, output write_all, output led_index, output red_level,
                  output green_level, output blue_level, output last_write, input ready);
  modport sink   (input valid, input write_all, input led_index, input red_level,
                  input green_level, input blue_level, input last_write, output ready);
endinterface

>>> hdl/led_color_wipe_sequencer_core.sv
// Channel   Dir  Payload
// in_i      in   now_ms (16 b free-running milliseconds)
// out_o     out  write_all, led_index, red/green/blue_level, last_write
//
// After a request with a new tick the first write follows the divides and planning, and
// each further write is offered as soon as the output register is free; the block returns
// to idle after the last of n writes (1 to LED_COUNT + 1). A repeated tick writes nothing.
// A new tick takes three reciprocal divides (tick, sweep, level), then the writes.
// rst_ni clears the sync point, tick and position history and all control state.
// A stalled output holds the write in the output register and pauses the sequence.
// Depends on lcws_pkg, lcws_in_if, lcws_out_if, lcws_ctrl, lcws_dp, assert_macros.svh.
`include "assert_macros.svh"

module led_color_wipe_sequencer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  lcws_in_if.sink      in_i,
  lcws_out_if.source   out_o
);
  import lcws_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_i.ready = in_ready;

  lcws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcws_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_now_ms_i   (in_i.now_ms),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .write_all_o   (out_o.write_all),
    .led_index_o   (out_o.led_index),
    .red_level_o   (out_o.red_level),
    .green_level_o (out_o.green_level),
    .blue_level_o  (out_o.blue_level),
    .last_write_o  (out_o.last_write)
  );

  // Sequence checks
  `LCWS_ASSERT_NEXT(a_busy_after_request, clk_i, rst_ni, in_i.valid && in_ready, !in_ready, "input ready right after a request")
  `LCWS_ASSERT_IMPLY(a_one_write_kind, clk_i, rst_ni, 1'b1, ($onehot0({cmd.emit_all, cmd.emit_fill, cmd.emit_last})), "several write kinds at once")
  `LCWS_ASSERT_IMPLY(a_write_needs_slot, clk_i, rst_ni, cmd.emit_all || cmd.emit_fill || cmd.emit_last, sts.out_free, "write issued into a full output register")
  `LCWS_ASSERT_NEXT(a_last_frees_input, clk_i, rst_ni, cmd.emit_last, in_ready, "input not ready after the final write")

endmodule

>>> hdl/lcws_div.sv
// Divider by one of three constants through reciprocal multiplication.
// Depends on lcws_pkg.
module lcws_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  lcws_pkg::div_op_e            op_i,
  input  logic [lcws_pkg::DIV_W-1:0]   dividend_i,
  output logic                         done_o,
  output logic [lcws_pkg::DIV_W-1:0]   quotient_o,
  output logic [lcws_pkg::DVS_W-1:0]   remainder_o
);
  import lcws_pkg::*;

  localparam int unsigned MUL_W  = DIV_W + REC_W;
  localparam int unsigned BACK_W = DIV_W + DVS_W;

  logic                 stage1_q;
  logic                 stage2_q;
  logic                 done_q;
  logic [DIV_W-1:0]     opnd_q;
  logic [REC_W-1:0]     recip_q;
  logic [SH_W-1:0]      shift_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W-1:0]     rem_q;

  logic [REC_W-1:0]     load_recip;
  logic [SH_W-1:0]      load_shift;
  logic [DVS_W-1:0]     load_dvs;
  logic [MUL_W-1:0]     mul_prod;
  logic [MUL_W-1:0]     mul_shr;
  logic [BACK_W-1:0]    back_prod;
  logic [DIV_W-1:0]     rem_full;

  // Select reciprocal, shift and divisor
  always_comb begin
    case (op_i)
      DIV_OP_TICK: begin
        load_recip = REC_W'(TICK_RECIP);
        load_shift = SH_W'(TICK_SH);
        load_dvs   = DVS_W'(TICK_MS);
      end
      DIV_OP_SWEEP: begin
        load_recip = REC_W'(SWEEP_RECIP);
        load_shift = SH_W'(SWEEP_SH);
        load_dvs   = DVS_W'(SWEEP_DIV);
      end
      DIV_OP_LEVEL: begin
        load_recip = REC_W'(LEVEL_RECIP);
        load_shift = SH_W'(LEVEL_SH);
        load_dvs   = DVS_W'(LEVEL_MAX);
      end
      default: begin
        load_recip = REC_W'(TICK_RECIP);
        load_shift = SH_W'(TICK_SH);
        load_dvs   = DVS_W'(TICK_MS);
      end
    endcase
  end

  // Quotient from the scaled product, remainder from the quotient
  assign mul_prod  = {{REC_W{1'b0}}, opnd_q} * {{DIV_W{1'b0}}, recip_q};
  assign mul_shr   = mul_prod >> shift_q;
  assign back_prod = {{DVS_W{1'b0}}, quo_q} * {{DIV_W{1'b0}}, dvs_q};
  assign rem_full  = opnd_q - back_prod[DIV_W-1:0];

  // Stage flags and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      stage1_q <= start_i;
      stage2_q <= stage1_q;
      done_q   <= stage2_q;
    end
  end

  // Operand capture, quotient, then remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q  <= dividend_i;
      recip_q <= load_recip;
      shift_q <= load_shift;
      dvs_q   <= load_dvs;
    end
    if (stage1_q) begin
      quo_q <= mul_shr[DIV_W-1:0];
    end
    if (stage2_q) begin
      rem_q <= rem_full[DVS_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> hdl/lcws_dp.sv
// Datapath: sync point, tick history, sweep arithmetic, wipe planning and output register.
// Depends on lcws_pkg and lcws_div.
module lcws_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lcws_pkg::TIME_W-1:0]   in_now_ms_i,
  input  lcws_pkg::dp_cmd_t             cmd_i,
  output lcws_pkg::dp_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          write_all_o,
  output logic [lcws_pkg::IDX_W-1:0]    led_index_o,
  output logic [lcws_pkg::LEVEL_W-1:0]  red_level_o,
  output logic [lcws_pkg::LEVEL_W-1:0]  green_level_o,
  output logic [lcws_pkg::LEVEL_W-1:0]  blue_level_o,
  output logic                          last_write_o
);
  import lcws_pkg::*;

  typedef enum logic [1:0] {
    PH_RED,
    PH_GREEN,
    PH_BLUE
  } phase_e;

  localparam logic [TIME_W-1:0]  SPAN_V = TIME_W'(SYNC_SPAN);
  localparam logic [K_W-1:0]     K_V    = K_W'(SWEEP_K);
  localparam logic [POS_W-1:0]   LC_V   = POS_W'(LED_COUNT);
  localparam logic [POS_W-1:0]   LC2_V  = POS_W'(2 * LED_COUNT);
  localparam logic [LEVEL_W-1:0] MX_V   = LEVEL_W'(LEVEL_MAX);

  // State and control registers
  logic [TIME_W-1:0]  sync_q;
  logic [TICK_W-1:0]  prev_tick_q;
  logic [POS_W-1:0]   prev_pos_q;
  logic               need_all_q;
  logic               out_valid_q;

  // Payload registers
  logic [TIME_W-1:0]  t_q;
  logic [PROD_W-1:0]  prod_q;
  logic [POS_W-1:0]   pos_q;
  logic [LEVEL_W-1:0] sub_q;
  phase_e             phase_q;
  logic [POS_W-1:0]   fill_q;
  logic               write_all_q;
  logic [IDX_W-1:0]   led_index_q;
  logic [LEVEL_W-1:0] red_q;
  logic [LEVEL_W-1:0] green_q;
  logic [LEVEL_W-1:0] blue_q;
  logic               last_q;

  // Divider
  logic [DIV_W-1:0]   div_dividend;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [DVS_W-1:0]   div_rem;

  logic [TICK_W-1:0]       tick;
  logic [K_W+TICK_W-1:0]   mul_full;
  logic [POS_W-1:0]        new_pos;
  logic [LEVEL_W-1:0]      new_sub;
  phase_e                  new_phase;
  logic                    new_need;
  logic [POS_W-1:0]        new_fill;
  logic [POS_W-1:0]        base;
  logic [POS_W-1:0]        fill_rel;
  logic [POS_W-1:0]        pos_rel;
  logic [LEVEL_W-1:0]      inv_sub;
  logic                    any_emit;
  logic                    out_free;

  // Feed the divider from the stage that asked
  always_comb begin
    case (cmd_i.div_op)
      DIV_OP_TICK:  div_dividend = DIV_W'(t_q);
      DIV_OP_SWEEP: div_dividend = DIV_W'(prod_q);
      DIV_OP_LEVEL: div_dividend = DIV_W'(div_quo[TIME_W-1:0]);
      default:      div_dividend = '0;
    endcase
  end

  lcws_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .op_i        (cmd_i.div_op),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Tick times sweep scale
  assign tick     = div_quo[TICK_W-1:0];
  assign mul_full = K_V * tick;

  // Choose the wipe phase from the new position
  assign new_pos = div_quo[POS_W-1:0];
  assign new_sub = div_rem[LEVEL_W-1:0];

  always_comb begin
    if (new_pos < LC_V) begin
      new_phase = PH_RED;
      new_need  = (prev_pos_q >= LC_V);
      new_fill  = new_need ? '0 : prev_pos_q;
    end else if (new_pos < LC2_V) begin
      new_phase = PH_GREEN;
      new_need  = (prev_pos_q <= LC_V);
      new_fill  = new_need ? LC_V : prev_pos_q;
    end else begin
      new_phase = PH_BLUE;
      new_need  = (prev_pos_q <= LC2_V);
      new_fill  = new_need ? LC2_V : prev_pos_q;
    end
  end

  always_comb begin
    case (phase_q)
      PH_RED:   base = '0;
      PH_GREEN: base = LC_V;
      PH_BLUE:  base = LC2_V;
      default:  base = '0;
    endcase
  end

  assign fill_rel = fill_q - base;
  assign pos_rel  = pos_q - base;
  assign inv_sub  = MX_V - sub_q;
  assign any_emit = cmd_i.emit_all | cmd_i.emit_fill | cmd_i.emit_last;
  assign out_free = ~out_valid_q | out_ready_i;

  // Sync point, tick history, position history and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= '0;
      prev_tick_q <= '0;
      prev_pos_q  <= '0;
      need_all_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.adjust && (t_q >= SPAN_V)) begin
        sync_q <= sync_q + SPAN_V;
      end
      if (cmd_i.tick_take) begin
        prev_tick_q <= tick;
      end
      if (cmd_i.plan) begin
        need_all_q <= new_need;
      end else if (cmd_i.emit_all) begin
        need_all_q <= 1'b0;
      end
      if (cmd_i.emit_last) begin
        prev_pos_q <= pos_q;
      end
      if (any_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working values and the write command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      t_q <= in_now_ms_i - sync_q;
    end else if (cmd_i.adjust && (t_q >= SPAN_V)) begin
      t_q <= t_q - SPAN_V;
    end
    if (cmd_i.tick_take) begin
      prod_q <= mul_full[PROD_W-1:0];
    end
    if (cmd_i.plan) begin
      pos_q   <= new_pos;
      sub_q   <= new_sub;
      phase_q <= new_phase;
      fill_q  <= new_fill;
    end else if (cmd_i.emit_fill) begin
      fill_q <= fill_q + 1'b1;
    end

    // Fill everything with the color of the phase before
    if (cmd_i.emit_all) begin
      write_all_q <= 1'b1;
      led_index_q <= '0;
      last_q      <= 1'b0;
      case (phase_q)
        PH_RED:   begin red_q <= '0;   green_q <= '0;   blue_q <= MX_V; end
        PH_GREEN: begin red_q <= MX_V; green_q <= '0;   blue_q <= '0;   end
        PH_BLUE:  begin red_q <= '0;   green_q <= MX_V; blue_q <= '0;   end
        default:  begin red_q <= '0;   green_q <= '0;   blue_q <= '0;   end
      endcase
    end
    // Passed LED takes the full color of this phase
    if (cmd_i.emit_fill) begin
      write_all_q <= 1'b0;
      led_index_q <= fill_rel[IDX_W-1:0];
      last_q      <= 1'b0;
      case (phase_q)
        PH_RED:   begin red_q <= MX_V; green_q <= '0;   blue_q <= '0;   end
        PH_GREEN: begin red_q <= '0;   green_q <= MX_V; blue_q <= '0;   end
        PH_BLUE:  begin red_q <= '0;   green_q <= '0;   blue_q <= MX_V; end
        default:  begin red_q <= '0;   green_q <= '0;   blue_q <= '0;   end
      endcase
    end
    // Current LED cross-fades from the old color into the new one
    if (cmd_i.emit_last) begin
      write_all_q <= 1'b0;
      led_index_q <= pos_rel[IDX_W-1:0];
      last_q      <= 1'b1;
      case (phase_q)
        PH_RED:   begin red_q <= sub_q;   green_q <= '0;      blue_q <= inv_sub; end
        PH_GREEN: begin red_q <= inv_sub; green_q <= sub_q;   blue_q <= '0;      end
        PH_BLUE:  begin red_q <= '0;      green_q <= inv_sub; blue_q <= sub_q;   end
        default:  begin red_q <= '0;      green_q <= '0;      blue_q <= '0;      end
      endcase
    end
  end

  // Status back to the controller
  assign sts_o.div_done    = div_done;
  assign sts_o.tick_repeat = (tick == prev_tick_q);
  assign sts_o.need_all    = need_all_q;
  assign sts_o.fill_more   = (fill_q < pos_q);
  assign sts_o.out_free    = out_free;

  assign out_valid_o   = out_valid_q;
  assign write_all_o   = write_all_q;
  assign led_index_o   = led_index_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;
  assign last_write_o  = last_q;

endmodule

>>> hdl/lcws_ctrl.sv
// Controller: sequences one time request through sync, divides, planning and writes.
// Depends on lcws_pkg.
module lcws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lcws_pkg::dp_sts_t   sts_i,
  output lcws_pkg::dp_cmd_t   cmd_o
);
  import lcws_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADJUST,
    ST_TICK_GO,
    ST_TICK_WAIT,
    ST_CHECK,
    ST_SWEEP_GO,
    ST_SWEEP_WAIT,
    ST_LEVEL_GO,
    ST_LEVEL_WAIT,
    ST_PLAN,
    ST_EMIT
  } state_e;

  state_e  state_q;
  state_e  state_d;
  dp_cmd_t cmd;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.div_op = DIV_OP_TICK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_ADJUST;
        end
      end
      ST_ADJUST: begin
        cmd.adjust = 1'b1;
        state_d    = ST_TICK_GO;
      end
      ST_TICK_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_OP_TICK;
        state_d       = ST_TICK_WAIT;
      end
      ST_TICK_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Drop a tick already seen
        if (sts_i.tick_repeat) begin
          state_d = ST_IDLE;
        end else begin
          cmd.tick_take = 1'b1;
          state_d       = ST_SWEEP_GO;
        end
      end
      ST_SWEEP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_OP_SWEEP;
        state_d       = ST_SWEEP_WAIT;
      end
      ST_SWEEP_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_LEVEL_GO;
        end
      end
      ST_LEVEL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_OP_LEVEL;
        state_d       = ST_LEVEL_WAIT;
      end
      ST_LEVEL_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd.plan = 1'b1;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        // One write per free output slot: full fill, passed LEDs, then the fading one
        if (sts_i.out_free) begin
          if (sts_i.need_all) begin
            cmd.emit_all = 1'b1;
          end else if (sts_i.fill_more) begin
            cmd.emit_fill = 1'b1;
          end else begin
            cmd.emit_last = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_ready_o = (state_q == ST_IDLE);

endmodule
